// ===== hdl/owm_pkg.sv =====
// shared types and constants of the one-wire slot timer
package owm_pkg;

  // configuration register width and index width
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // default tick counter width
  localparam int TIMER_BITS_DEF = 10;

  // bits moved by a byte command
  localparam int BITS_PER_BYTE = 8;
  localparam int BL_W          = $clog2(BITS_PER_BYTE + 1);

  // command codes
  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_RESET      = 3'd1;
  localparam logic [2:0] KIND_WRITE_BIT  = 3'd2;
  localparam logic [2:0] KIND_READ_BIT   = 3'd3;
  localparam logic [2:0] KIND_WRITE_BYTE = 3'd4;
  localparam logic [2:0] KIND_READ_BYTE  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_REC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DLY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LEN   = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0] RST_RESET_LOW  = 10'd480;
  localparam logic [CFG_W-1:0] RST_PRES_WAIT  = 10'd70;
  localparam logic [CFG_W-1:0] RST_RESET_REC  = 10'd410;
  localparam logic [CFG_W-1:0] RST_SHORT_LOW  = 10'd6;
  localparam logic [CFG_W-1:0] RST_LONG_LOW   = 10'd60;
  localparam logic [CFG_W-1:0] RST_SAMPLE_DLY = 10'd9;
  localparam logic [CFG_W-1:0] RST_SLOT_LEN   = 10'd70;

  // sequencer phases
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_RST_LOW   = 6'b000010,
    PH_RST_WAIT  = 6'b000100,
    PH_RST_REC   = 6'b001000,
    PH_SLOT_BIT  = 6'b010000,
    PH_SLOT_BYTE = 6'b100000
  } phase_t;

  // one result beat
  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } owm_res_t;

endpackage

// ===== hdl/owm_ifs.sv =====
// handshake channels of the one-wire slot timer

interface owm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_in;
  logic       line_level;

  modport source (output valid, output kind, output data_in, output line_level,
                  input ready);
  modport sink   (input valid, input kind, input data_in, input line_level,
                  output ready);
endinterface

interface owm_res_if;
  logic       valid;
  logic       ready;
  logic       pull_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, output pull_low, output busy_res, output done_res,
                  output presence, output read_data, input ready);
  modport sink   (input valid, input pull_low, input busy_res, input done_res,
                  input presence, input read_data, output ready);
endinterface

interface owm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/one_wire_master_slot_timer_core.sv =====
// one-wire bus master: reset, bit and byte slot sequencer on microsecond ticks
// each result beat is registered in the head (or, under a stall, the skid) register
// throughput: one beat per cycle while out_res is not stalled; a two-entry result
//   buffer keeps in_cmd ready for one extra beat while out_res is stalled
// reset: synchronous active-low rst_n clears the sequencer to idle, empties the
//   result buffer and loads the timing registers with their default values
module one_wire_master_slot_timer_core
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  owm_cmd_if.sink  in_cmd,
  owm_res_if.source out_res,
  owm_cfg_if.sink  cfg_wr
);

  // compare width covers both the timer and the register fields
  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  // ---------------------------------------------------------------------------
  // timing registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] reset_low_r, pres_wait_r, reset_rec_r;
  logic [CFG_W-1:0] short_low_r, long_low_r, sample_dly_r, slot_len_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r  <= RST_RESET_LOW;
      pres_wait_r  <= RST_PRES_WAIT;
      reset_rec_r  <= RST_RESET_REC;
      short_low_r  <= RST_SHORT_LOW;
      long_low_r   <= RST_LONG_LOW;
      sample_dly_r <= RST_SAMPLE_DLY;
      slot_len_r   <= RST_SLOT_LEN;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_RESET_LOW:  reset_low_r  <= cfg_wr.data;
        REG_PRES_WAIT:  pres_wait_r  <= cfg_wr.data;
        REG_RESET_REC:  reset_rec_r  <= cfg_wr.data;
        REG_SHORT_LOW:  short_low_r  <= cfg_wr.data;
        REG_LONG_LOW:   long_low_r   <= cfg_wr.data;
        REG_SAMPLE_DLY: sample_dly_r <= cfg_wr.data;
        REG_SLOT_LEN:   slot_len_r   <= cfg_wr.data;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // clamp a register value to the largest count the timer holds
  function automatic logic [TIMER_BITS-1:0] lim(input logic [CFG_W-1:0] x);
    logic [CW-1:0] xw;
    xw = CW'(x);
    return (xw > CW'(TMAX)) ? TMAX : xw[TIMER_BITS-1:0];
  endfunction

  logic [TIMER_BITS-1:0] lim_reset_low, lim_pres_wait, lim_reset_rec;
  logic [TIMER_BITS-1:0] lim_short, lim_long, lim_sample, lim_slot;
  logic [TIMER_BITS-1:0] slot_end;
  logic [TIMER_BITS:0]   samp_sum;
  logic [TIMER_BITS-1:0] samp_pt;

  assign lim_reset_low = lim(reset_low_r);
  assign lim_pres_wait = lim(pres_wait_r);
  assign lim_reset_rec = lim(reset_rec_r);
  assign lim_short     = lim(short_low_r);
  assign lim_long      = lim(long_low_r);
  assign lim_sample    = lim(sample_dly_r);
  assign lim_slot      = lim(slot_len_r);

  // slot end is at least one tick
  assign slot_end = (lim_slot == '0) ? TIMER_BITS'(1) : lim_slot;

  // read sample point: short low plus sample delay, at least one, at most slot end
  assign samp_sum = {1'b0, lim_short} + {1'b0, lim_sample};
  always_comb begin
    if (samp_sum == '0) begin
      samp_pt = TIMER_BITS'(1);
    end else if (samp_sum > {1'b0, slot_end}) begin
      samp_pt = slot_end;
    end else begin
      samp_pt = samp_sum[TIMER_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------------
  phase_t                phase_r,     phase_nxt;
  logic [TIMER_BITS-1:0] tick_r,      tick_nxt;
  logic [BL_W-1:0]       bits_left_r, bits_left_nxt;
  logic [7:0]            shift_r,     shift_nxt;
  logic                  presence_r,  presence_nxt;
  logic                  is_read_r,   is_read_nxt;
  logic [7:0]            read_hold_r, read_hold_nxt;

  logic                  push, pop;
  logic                  done;
  logic [TIMER_BITS-1:0] cnt;
  logic [BL_W-1:0]       bits_dec;
  logic [TIMER_BITS-1:0] low_time;
  logic                  pull;
  owm_res_t              res;

  // result buffer: head register drives out_res, skid register catches one
  // more beat while the head is stalled
  owm_res_t head_r, skid_r;
  logic     head_v_r, skid_v_r;

  assign in_cmd.ready = !skid_v_r;
  assign push = in_cmd.valid && in_cmd.ready;
  assign pop  = head_v_r && out_res.ready;

  assign cnt = (tick_r == TMAX) ? TMAX : tick_r + TIMER_BITS'(1);

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    presence_nxt  = presence_r;
    is_read_nxt   = is_read_r;
    read_hold_nxt = read_hold_r;
    done          = 1'b0;
    bits_dec      = bits_left_r;

    if (push) begin
      if (in_cmd.kind == KIND_TICK) begin
        // time only moves while a sequence runs
        if (phase_r != PH_IDLE) begin
          tick_nxt = cnt;
          unique case (phase_r)
            PH_RST_LOW: begin
              if (cnt >= lim_reset_low) begin
                phase_nxt = PH_RST_WAIT;
                tick_nxt  = '0;
              end
            end
            PH_RST_WAIT: begin
              // a device answering pulls the line low
              if (cnt >= lim_pres_wait) begin
                presence_nxt = !in_cmd.line_level;
                phase_nxt    = PH_RST_REC;
                tick_nxt     = '0;
              end
            end
            PH_RST_REC: begin
              if (cnt >= lim_reset_rec) begin
                phase_nxt = PH_IDLE;
                tick_nxt  = '0;
                done      = 1'b1;
              end
            end
            PH_SLOT_BIT, PH_SLOT_BYTE: begin
              // read sample, lsb first: bit 0 for a bit, shifter top for a byte
              if (is_read_r && cnt == samp_pt) begin
                if (phase_r == PH_SLOT_BIT) begin
                  shift_nxt = {7'd0, in_cmd.line_level};
                end else begin
                  shift_nxt = {in_cmd.line_level, shift_r[7:1]};
                end
              end
              // end of slot: next bit or finish
              if (cnt >= slot_end) begin
                if (!is_read_r) begin
                  shift_nxt = {1'b0, shift_r[7:1]};
                end
                if (bits_left_r != '0) begin
                  bits_dec = bits_left_r - BL_W'(1);
                end
                bits_left_nxt = bits_dec;
                tick_nxt      = '0;
                if (bits_dec == '0) begin
                  if (is_read_r) begin
                    read_hold_nxt = shift_nxt;
                  end
                  phase_nxt = PH_IDLE;
                  done      = 1'b1;
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
            end
          endcase
        end
      end else if (phase_r == PH_IDLE) begin
        // commands start only from idle, otherwise they are dropped
        unique case (in_cmd.kind)
          KIND_RESET: begin
            phase_nxt    = PH_RST_LOW;
            tick_nxt     = '0;
            presence_nxt = 1'b0;
          end
          KIND_WRITE_BIT: begin
            phase_nxt     = PH_SLOT_BIT;
            is_read_nxt   = 1'b0;
            bits_left_nxt = BL_W'(1);
            shift_nxt     = {7'd0, in_cmd.data_in[0]};
            tick_nxt      = '0;
          end
          KIND_READ_BIT: begin
            phase_nxt     = PH_SLOT_BIT;
            is_read_nxt   = 1'b1;
            bits_left_nxt = BL_W'(1);
            shift_nxt     = '0;
            tick_nxt      = '0;
          end
          KIND_WRITE_BYTE: begin
            phase_nxt     = PH_SLOT_BYTE;
            is_read_nxt   = 1'b0;
            bits_left_nxt = BL_W'(BITS_PER_BYTE);
            shift_nxt     = in_cmd.data_in;
            tick_nxt      = '0;
          end
          KIND_READ_BYTE: begin
            phase_nxt     = PH_SLOT_BYTE;
            is_read_nxt   = 1'b1;
            bits_left_nxt = BL_W'(BITS_PER_BYTE);
            shift_nxt     = '0;
            tick_nxt      = '0;
          end
          default: ; // undefined kinds do nothing
        endcase
      end
    end
  end

  // line drive after the beat: reset pulse, or the low part of a slot
  assign low_time = (is_read_nxt || shift_nxt[0]) ? lim_short : lim_long;

  always_comb begin
    pull = 1'b0;
    if (phase_nxt == PH_RST_LOW) begin
      pull = 1'b1;
    end else if ((phase_nxt == PH_SLOT_BIT || phase_nxt == PH_SLOT_BYTE)
                 && tick_nxt < low_time) begin
      pull = 1'b1;
    end
  end

  always_comb begin
    res.pull_low  = pull;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_nxt;
    res.read_data = read_hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bits_left_r <= '0;
      shift_r     <= '0;
      presence_r  <= 1'b0;
      is_read_r   <= 1'b0;
      read_hold_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bits_left_r <= bits_left_nxt;
      shift_r     <= shift_nxt;
      presence_r  <= presence_nxt;
      is_read_r   <= is_read_nxt;
      read_hold_r <= read_hold_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result buffer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!head_v_r) begin
        head_v_r <= push;
      end else if (pop) begin
        if (skid_v_r) begin
          // skid full means no push this cycle
          skid_v_r <= 1'b0;
        end else begin
          head_v_r <= push;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_v_r || (pop && !skid_v_r)) begin
      head_r <= res;
    end else if (pop) begin
      head_r <= skid_r;
    end
    if (head_v_r && !pop && push) begin
      skid_r <= res;
    end
  end

  assign out_res.valid     = head_v_r;
  assign out_res.pull_low  = head_r.pull_low;
  assign out_res.busy_res  = head_r.busy_res;
  assign out_res.done_res  = head_r.done_res;
  assign out_res.presence  = head_r.presence;
  assign out_res.read_data = head_r.read_data;

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the one-wire bus master slot timer core
module tb;
  import owm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // kinds the block ignores, no names for them in the package
  localparam logic [2:0] KIND_NOP_LO = 3'd6;
  localparam logic [2:0] KIND_NOP_HI = 3'd7;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // tick counter saturates here; at the default width no register can exceed it
  localparam logic [TIMER_BITS_DEF-1:0] TICK_MAX = '1;

  // random part: one timing setting per segment, idling picked by segment pair
  localparam int SEGMENTS       = 6;
  localparam int ZERO_SEGMENT   = 1;  // every register zero
  localparam int WIDE_SEGMENT   = 3;  // low times and sample delay full scale
  localparam int LIVE_PER_SEG   = 60;
  localparam int SEND_IDLE [3]  = '{8, 58, 0};
  localparam int RECV_STALL [3] = '{58, 8, 0};

  // cycles with no beat on any channel before the run is called hung
  localparam int QUIET_LIMIT = 2000;

  // directed rows: either a command/tick beat or a register write
  localparam logic ROW_BEAT  = 1'b0;
  localparam logic ROW_REG   = 1'b1;
  localparam logic USE_MODEL = 1'b0;
  localparam logic USE_FIXED = 1'b1;

  // results that can be read off without working through the sequencer
  localparam owm_res_t RES_QUIET     = '0;
  localparam owm_res_t RES_RST_START = '{pull_low: 1'b1, busy_res: 1'b1, default: '0};

  typedef struct packed {
    logic             kind_of_row;
    logic [2:0]       code;   // command kind or register index
    logic [CFG_W-1:0] val;    // data byte or register value
    logic             line;
    logic             check;
    owm_res_t         want;
  } stim_row_t;

  localparam int DIR_N = 46;

  // short directed walk: idle no-ops, a tiny reset with presence, bit slots,
  // then one-tick byte slots with the read sample set past the slot end and clamped
  stim_row_t dir_rows [DIR_N] = '{
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_FIXED, RES_QUIET},
    '{ROW_BEAT, KIND_NOP_HI,     10'h0ff, 1'b1, USE_FIXED, RES_QUIET},
    '{ROW_BEAT, KIND_NOP_LO,     10'h000, 1'b0, USE_FIXED, RES_QUIET},
    '{ROW_REG,  REG_RESET_LOW,   10'd1,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_PRES_WAIT,   10'd1,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_RESET_REC,   10'd1,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SHORT_LOW,   10'd1,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_LONG_LOW,    10'd2,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SAMPLE_DLY,  10'd0,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SLOT_LEN,    10'd3,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SPARE,       10'h3ff, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_RESET,      10'h000, 1'b0, USE_FIXED, RES_RST_START},
    '{ROW_BEAT, KIND_WRITE_BIT,  10'h001, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_WRITE_BIT,  10'h0fe, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_READ_BIT,   10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SLOT_LEN,    10'd0,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SHORT_LOW,   10'd0,   1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_SAMPLE_DLY,  10'h3ff, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_REG,  REG_LONG_LOW,    10'h3ff, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_READ_BYTE,  10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_WRITE_BYTE, 10'h0a5, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b1, USE_MODEL, RES_QUIET},
    '{ROW_BEAT, KIND_TICK,       10'h000, 1'b0, USE_MODEL, RES_QUIET}
  };

  logic clk = 1'b0;
  logic rst_n;

  owm_cmd_if in_cmd ();
  owm_res_if out_res ();
  owm_cfg_if cfg_wr ();

  one_wire_master_slot_timer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_cmd),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  always #5 clk = ~clk;

  // sequencer mirror: timing registers plus the state the bus master keeps
  logic [CFG_W-1:0]          timing [8];   // the spare index lands in slot 7, never read
  phase_t                    seq_phase;
  logic [TIMER_BITS_DEF-1:0] tick_cnt;
  logic [BL_W-1:0]           bits_todo;
  logic [7:0]                shreg;
  logic [7:0]                last_read;
  logic                      pres_flag;
  logic                      rd_slot;

  // results still owed by the block, oldest first
  owm_res_t pending_res [$];

  int in_idle_pct;
  int out_stall_pct;
  int beats_sent;
  int live_beats;
  int results_checked;
  int reg_writes;
  int errors;
  int quiet_cycles;

  // back to the state right after rst_n
  task automatic clear_model();
    timing[REG_RESET_LOW]  = RST_RESET_LOW;
    timing[REG_PRES_WAIT]  = RST_PRES_WAIT;
    timing[REG_RESET_REC]  = RST_RESET_REC;
    timing[REG_SHORT_LOW]  = RST_SHORT_LOW;
    timing[REG_LONG_LOW]   = RST_LONG_LOW;
    timing[REG_SAMPLE_DLY] = RST_SAMPLE_DLY;
    timing[REG_SLOT_LEN]   = RST_SLOT_LEN;
    timing[REG_SPARE]      = '0;
    seq_phase = PH_IDLE;
    tick_cnt  = '0;
    bits_todo = '0;
    shreg     = '0;
    last_read = '0;
    pres_flag = 1'b0;
    rd_slot   = 1'b0;
  endtask

  // one beat through the sequencer; returns the bus state after it
  function automatic owm_res_t bus_step(input logic [2:0] kind, input logic [7:0] data,
                                        input logic line);
    logic [TIMER_BITS_DEF-1:0] cnt;
    logic [CFG_W-1:0]          slot_end;
    logic [CFG_W-1:0]          low_t;
    logic [CFG_W:0]            samp_at;
    logic                      fin;
    owm_res_t                  r;

    fin = 1'b0;
    if (kind == KIND_TICK) begin
      // ticks only count while a sequence runs
      if (seq_phase != PH_IDLE) begin
        cnt = (tick_cnt < TICK_MAX) ? tick_cnt + 1'b1 : TICK_MAX;
        case (seq_phase)
          PH_RST_LOW: begin
            if (cnt >= timing[REG_RESET_LOW]) begin
              seq_phase = PH_RST_WAIT;
              cnt = '0;
            end
          end
          PH_RST_WAIT: begin
            // a device answers by holding the line low
            if (cnt >= timing[REG_PRES_WAIT]) begin
              pres_flag = ~line;
              seq_phase = PH_RST_REC;
              cnt = '0;
            end
          end
          PH_RST_REC: begin
            if (cnt >= timing[REG_RESET_REC]) begin
              seq_phase = PH_IDLE;
              cnt = '0;
              fin = 1'b1;
            end
          end
          PH_SLOT_BIT, PH_SLOT_BYTE: begin
            // zero length still gives a one-tick slot
            slot_end = (timing[REG_SLOT_LEN] == '0) ? CFG_W'(1) : timing[REG_SLOT_LEN];
            // read sample point, pulled back to the last tick of the slot
            samp_at = {1'b0, timing[REG_SHORT_LOW]} + {1'b0, timing[REG_SAMPLE_DLY]};
            if (samp_at == '0) samp_at = (CFG_W + 1)'(1);
            if (samp_at > {1'b0, slot_end}) samp_at = {1'b0, slot_end};
            if (rd_slot && cnt == samp_at[CFG_W-1:0]) begin
              shreg = (seq_phase == PH_SLOT_BIT) ? {7'b0, line} : {line, shreg[7:1]};
            end
            if (cnt >= slot_end) begin
              if (!rd_slot) shreg = shreg >> 1;
              if (bits_todo != '0) bits_todo = bits_todo - 1'b1;
              cnt = '0;
              if (bits_todo == '0) begin
                if (rd_slot) last_read = shreg;
                seq_phase = PH_IDLE;
                fin = 1'b1;
              end
            end
          end
          default: begin
            seq_phase = PH_IDLE;
            cnt = '0;
          end
        endcase
        tick_cnt = cnt;
      end
    end else if (seq_phase == PH_IDLE) begin
      // commands start only from idle; when busy they are dropped
      case (kind)
        KIND_RESET: begin
          seq_phase = PH_RST_LOW;
          pres_flag = 1'b0;
        end
        KIND_WRITE_BIT: begin
          seq_phase = PH_SLOT_BIT;
          rd_slot   = 1'b0;
          bits_todo = BL_W'(1);
          shreg     = {7'b0, data[0]};
        end
        KIND_READ_BIT: begin
          seq_phase = PH_SLOT_BIT;
          rd_slot   = 1'b1;
          bits_todo = BL_W'(1);
          shreg     = '0;
        end
        KIND_WRITE_BYTE: begin
          seq_phase = PH_SLOT_BYTE;
          rd_slot   = 1'b0;
          bits_todo = BL_W'(BITS_PER_BYTE);
          shreg     = data;
        end
        KIND_READ_BYTE: begin
          seq_phase = PH_SLOT_BYTE;
          rd_slot   = 1'b1;
          bits_todo = BL_W'(BITS_PER_BYTE);
          shreg     = '0;
        end
        default: ;
      endcase
      // counter is already zero whenever idle
      tick_cnt = '0;
    end

    // low time of the slot follows the bit now at the bottom of the shifter
    low_t = (rd_slot || shreg[0]) ? timing[REG_SHORT_LOW] : timing[REG_LONG_LOW];
    r.pull_low  = (seq_phase == PH_RST_LOW) ||
                  ((seq_phase == PH_SLOT_BIT || seq_phase == PH_SLOT_BYTE) && tick_cnt < low_t);
    r.busy_res  = (seq_phase != PH_IDLE);
    r.done_res  = fin;
    r.presence  = pres_flag;
    r.read_data = last_read;
    return r;
  endfunction

  task automatic report_miss(input string what, input int got, input int want);
    errors++;
    $display("mismatch on result %0d: %s got %0h want %0h", results_checked, what, got, want);
  endtask

  // one beat on in_cmd, with random sender gaps ahead of it
  task automatic send_beat(input logic [2:0] kind, input logic [7:0] data, input logic line,
                           input logic check, input owm_res_t want);
    owm_res_t predicted;

    while (int'($urandom_range(99)) < in_idle_pct) begin
      @(negedge clk);
      in_cmd.valid <= 1'b0;
    end
    @(negedge clk);
    in_cmd.valid      <= 1'b1;
    in_cmd.kind       <= kind;
    in_cmd.data_in    <= data;
    in_cmd.line_level <= line;
    do @(posedge clk); while (!in_cmd.ready);
    // beats that start a sequence or tick a running one
    if (kind <= KIND_READ_BYTE && ((kind == KIND_TICK) == (seq_phase != PH_IDLE)))
      live_beats++;
    beats_sent++;
    predicted = bus_step(kind, data, line);
    pending_res.push_back((check == USE_FIXED) ? want : predicted);
  endtask

  // sender holds off until every owed result has come back
  task automatic settle();
    @(negedge clk);
    in_cmd.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  // registers change only with the block drained
  task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    do @(posedge clk); while (!cfg_wr.ready);
    timing[idx] = value;
    reg_writes++;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  // one command followed by ticks until it finishes, with junk commands and
  // the occasional full drain mixed into the ticks
  task automatic run_op(input logic [2:0] op);
    int pick;

    send_beat(op, 8'($urandom), 1'($urandom), USE_MODEL, RES_QUIET);
    while (seq_phase != PH_IDLE) begin
      pick = int'($urandom_range(99));
      if (pick < 6)
        send_beat(3'($urandom_range(KIND_RESET, KIND_NOP_HI)), 8'($urandom), 1'($urandom),
                  USE_MODEL, RES_QUIET);
      else if (pick < 8)
        settle();
      else
        send_beat(KIND_TICK, 8'($urandom), 1'($urandom), USE_MODEL, RES_QUIET);
    end
  endtask

  // timing setting of one random segment
  task automatic program_segment(input int seg);
    logic [CFG_W-1:0] value;

    for (logic [CFG_IDX_W-1:0] r = REG_RESET_LOW; r <= REG_SLOT_LEN; r++) begin
      if (seg == ZERO_SEGMENT)
        value = '0;
      else if (seg == WIDE_SEGMENT && (r == REG_SHORT_LOW || r == REG_LONG_LOW ||
                                       r == REG_SAMPLE_DLY))
        value = '1;
      else
        value = CFG_W'($urandom_range(0, (r == REG_SLOT_LEN) ? 5 : 4));
      write_timing(r, value);
    end
    if (seg == SEGMENTS - 1) write_timing(REG_SPARE, CFG_W'($urandom));
  endtask

  // receiver stalls, one fresh decision per cycle
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_res.ready <= (int'($urandom_range(99)) >= out_stall_pct);
    end
  end

  // result checker: every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    owm_res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_res.size() == 0) begin
        report_miss("result beat with nothing owed", 0, 0);
      end else begin
        want = pending_res.pop_front();
        if (out_res.pull_low !== want.pull_low)
          report_miss("pull_low", int'(out_res.pull_low), int'(want.pull_low));
        if (out_res.busy_res !== want.busy_res)
          report_miss("busy_res", int'(out_res.busy_res), int'(want.busy_res));
        if (out_res.done_res !== want.done_res)
          report_miss("done_res", int'(out_res.done_res), int'(want.done_res));
        if (out_res.presence !== want.presence)
          report_miss("presence", int'(out_res.presence), int'(want.presence));
        if (out_res.read_data !== want.read_data)
          report_miss("read_data", int'(out_res.read_data), int'(want.read_data));
      end
      results_checked++;
    end
  end

  // hang detector: any beat on any channel restarts the count
  always @(posedge clk) begin
    if ((in_cmd.valid && in_cmd.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results owed", quiet_cycles,
               pending_res.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int live_mark;

    rst_n             = 1'b0;
    in_cmd.valid      = 1'b0;
    in_cmd.kind       = KIND_TICK;
    in_cmd.data_in    = '0;
    in_cmd.line_level = 1'b1;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = REG_RESET_LOW;
    cfg_wr.data       = '0;
    in_idle_pct       = SEND_IDLE[0];
    out_stall_pct     = RECV_STALL[0];
    beats_sent        = 0;
    live_beats        = 0;
    results_checked   = 0;
    reg_writes        = 0;
    errors            = 0;
    quiet_cycles      = 0;
    clear_model();

    // single synchronous reset at the start
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind_of_row == ROW_REG)
        write_timing(dir_rows[i].code, dir_rows[i].val);
      else
        send_beat(dir_rows[i].code, dir_rows[i].val[7:0], dir_rows[i].line,
                  dir_rows[i].check, dir_rows[i].want);
    end

    // random segments; sender-light first, then receiver-light, then no idling
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      in_idle_pct   = SEND_IDLE[seg / 2];
      out_stall_pct = RECV_STALL[seg / 2];
      program_segment(seg);
      live_mark = live_beats;
      while (live_beats - live_mark < LIVE_PER_SEG) begin
        // mostly whole sequences, now and then an idle no-op
        case ($urandom_range(0, 15))
          0: send_beat(KIND_TICK, 8'($urandom), 1'($urandom), USE_MODEL, RES_QUIET);
          1: send_beat(KIND_NOP_LO, 8'($urandom), 1'($urandom), USE_MODEL, RES_QUIET);
          2: send_beat(KIND_NOP_HI, 8'($urandom), 1'($urandom), USE_MODEL, RES_QUIET);
          default: run_op(3'($urandom_range(KIND_RESET, KIND_READ_BYTE)));
        endcase
      end
    end

    // drain, then wait to catch stray result beats
    settle();
    repeat (4) @(posedge clk);

    $display("%0d beats sent (%0d of them live), %0d results checked, %0d register writes",
             beats_sent, live_beats, results_checked, reg_writes);
    $display("timing from all-zero to full scale, stalls on either side and none, %0d errors",
             errors);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
